// ===== hdl/spa_pkg.sv =====
// Package with shared types, constants and codes for the segment page allocator.
`timescale 1ns / 1ps
package spa_pkg;
  localparam int PAGES_DEF    = 64;
  localparam int SEGMENTS_DEF = 16;
  localparam logic [12:0] PSZ_RESET = 13'd4;

  localparam logic [2:0] KIND_ALLOC  = 3'd0;
  localparam logic [2:0] KIND_FREE   = 3'd1;
  localparam logic [2:0] KIND_EVICT  = 3'd2;
  localparam logic [2:0] KIND_TOUCH  = 3'd3;
  localparam logic [2:0] KIND_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] process_id;
    logic [15:0] size_units;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] segment_number;
    logic [5:0]  page_index;
    logic        page_valid;
    logic [6:0]  page_total;
    logic [15:0] victim_process;
    logic        write_back;
    logic        present;
    logic        last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request
    logic div_step;  // one step of the page count division
    logic find_step; // examine one age position for the process
    logic walk_step; // examine one age position for second chance
    logic create;    // create segment
    logic page_step; // examine one page during allocate
    logic rel_step;  // examine one page during release
    logic shift_step;// close the gap in the age order by one entry
    logic finish_rm; // finish removal
    logic touch;     // set referenced bit at found position
    logic emit;      // present a result built from the current state
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic no_space;
    logic table_full;
    logic empty;
    logic need_zero;
    logic find_done;
    logic found;
    logic walk_done;
    logic page_done;
    logic rel_done;
    logic shift_done;
  } sts_t;
endpackage

// ===== hdl/spa_datapath.sv =====
// Datapath of the segment page allocator: tables, page pool, scan counters.
`timescale 1ns / 1ps
module spa_datapath #(
  parameter int PAGES    = spa_pkg::PAGES_DEF,
  parameter int SEGMENTS = spa_pkg::SEGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  spa_pkg::req_t req,
  input  logic [12:0]   psz_reg,
  input  spa_pkg::cmd_t cmd,
  output spa_pkg::sts_t sts,
  output spa_pkg::rsp_t rsp,
  output logic          strobe
);
  import spa_pkg::*;
  localparam int PW = $clog2(PAGES);
  localparam int SW = $clog2(SEGMENTS);
  localparam int CW = $clog2(PAGES + 1);
  localparam int LW = $clog2(SEGMENTS + 1);

  req_t r;
  logic [PAGES-1:0]    page_used;
  logic [CW-1:0]       free_cnt;
  logic [SEGMENTS-1:0] slot_valid, slot_ref, slot_mod;
  logic [15:0]         slot_process [SEGMENTS];
  logic [15:0]         slot_number  [SEGMENTS];
  logic [PAGES-1:0]    slot_mask    [SEGMENTS];
  logic [SW-1:0]       age_order    [SEGMENTS];
  logic [LW-1:0]       order_len;
  logic [SW-1:0]       hand;
  logic [15:0]         next_number;

  // Restoring divider for ceil(size / psz): quotient of size + psz - 1.
  logic [16:0] dividend;
  logic [16:0] quot;
  logic [17:0] rem;
  logic [4:0]  div_cnt;
  logic [12:0] psz;
  logic [17:0] rem_sh;
  logic [17:0] need;

  logic [LW-1:0] pos;       // age position counter
  logic [PW:0]   page;      // page scan counter
  logic [SW-1:0] cur_slot;  // slot being created or removed
  logic [CW-1:0] taken, released;
  logic [SW:0]   free_slot;
  logic [15:0]   num_hold, vic_hold;
  logic          wb_hold;
  logic          found;
  logic          created;
  logic [LW-1:0] found_pos;

  rsp_t          rsp_next;
  logic          strobe_next;
  logic [PW-1:0] page_idx;

  assign page_idx = page[PW-1:0];

  always_comb begin
    psz    = (psz_reg == '0) ? 13'd1 : psz_reg;
    rem_sh = {rem[16:0], dividend[16]};
    need   = {1'b0, quot};
  end

  always_comb begin
    free_slot = (SW+1)'(SEGMENTS);
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_slot = (SW+1)'(i);
    end
  end

  logic [SW-1:0] pos_slot;
  logic [SW-1:0] pos_idx;
  assign pos_idx  = pos[SW-1:0];
  assign pos_slot = age_order[pos_idx];

  always_comb begin
    sts = '0;
    sts.div_done   = (div_cnt == 5'd17);
    sts.no_space   = (free_cnt == '0) || (need > 18'(free_cnt));
    sts.table_full = (order_len >= LW'(SEGMENTS)) || free_slot[SW];
    sts.empty      = (order_len == '0);
    sts.need_zero  = (need == '0);
    sts.find_done  = found || (pos >= order_len);
    sts.found      = found;
    sts.walk_done  = found;
    sts.page_done  = (18'(taken) == need) || (page >= (PW+1)'(PAGES));
    sts.rel_done   = (page >= (PW+1)'(PAGES));
    sts.shift_done = (32'(pos) + 1 >= 32'(order_len));
  end

  // Each page taken and each final answer is one strobed transaction.
  always_comb begin
    rsp_next    = rsp;
    strobe_next = 1'b0;
    if (cmd.load) rsp_next = '0;
    if (cmd.page_step && !page_used[page_idx]) begin
      rsp_next                = '0;
      rsp_next.status         = ST_OK;
      rsp_next.segment_number = num_hold;
      rsp_next.page_index     = 6'(page_idx);
      rsp_next.page_valid     = 1'b1;
      rsp_next.page_total     = 7'(need);
      rsp_next.last           = (18'(taken) + 18'd1 == need);
      strobe_next             = 1'b1;
    end
    if (cmd.emit) begin
      rsp_next      = '0;
      rsp_next.last = 1'b1;
      strobe_next   = 1'b1;
      case (r.kind)
        KIND_ALLOC: begin
          if (created)            rsp_next.segment_number = num_hold;
          else if (sts.no_space)  rsp_next.status = ST_NO_SPACE;
          else                    rsp_next.status = ST_FULL;
        end
        KIND_FREE: begin
          if (!found) rsp_next.status = ST_NOT_FND;
          else begin
            rsp_next.segment_number = num_hold;
            rsp_next.page_total     = 7'(released);
          end
        end
        KIND_EVICT: begin
          if (sts.empty && !found) rsp_next.status = ST_EMPTY;
          else begin
            rsp_next.segment_number = num_hold;
            rsp_next.page_total     = 7'(released);
            rsp_next.victim_process = vic_hold;
            rsp_next.write_back     = wb_hold;
          end
        end
        KIND_TOUCH: begin
          if (!found) rsp_next.status = ST_NOT_FND;
          else rsp_next.segment_number = num_hold;
        end
        default: begin
          if (found) begin
            rsp_next.segment_number = num_hold;
            rsp_next.present        = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp    <= '0;
      strobe <= 1'b0;
    end else begin
      rsp    <= rsp_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_used   <= '0;
      free_cnt    <= CW'(PAGES);
      slot_valid  <= '0;
      slot_ref    <= '0;
      slot_mod    <= '0;
      order_len   <= '0;
      hand        <= '0;
      next_number <= '0;
      found       <= 1'b0;
      created     <= 1'b0;
    end else begin
      if (cmd.load) begin
        r         <= req;
        dividend  <= 17'(req.size_units) + 17'(psz) - 17'd1;
        quot      <= '0;
        rem       <= '0;
        div_cnt   <= '0;
        pos       <= (req.kind == KIND_EVICT && LW'(hand) < order_len) ? LW'(hand) : '0;
        page      <= '0;
        taken     <= '0;
        released  <= '0;
        found     <= 1'b0;
        created   <= 1'b0;
      end
      if (cmd.div_step) begin
        dividend <= {dividend[15:0], 1'b0};
        if (rem_sh >= 18'(psz)) begin
          rem  <= rem_sh - 18'(psz);
          quot <= {quot[15:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[15:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      if (cmd.find_step) begin
        if (slot_valid[pos_slot] && slot_process[pos_slot] == r.process_id) begin
          found     <= 1'b1;
          found_pos <= pos;
          cur_slot  <= pos_slot;
          num_hold  <= slot_number[pos_slot];
        end else begin
          pos <= pos + LW'(1);
        end
      end
      if (cmd.walk_step) begin
        if (!slot_ref[pos_slot]) begin
          found     <= 1'b1;
          found_pos <= pos;
          cur_slot  <= pos_slot;
          num_hold  <= slot_number[pos_slot];
          vic_hold  <= slot_process[pos_slot];
          wb_hold   <= slot_mod[pos_slot];
        end else begin
          slot_ref[pos_slot] <= 1'b0;
          slot_mod[pos_slot] <= 1'b1;
          pos <= (pos + LW'(1) < order_len) ? pos + LW'(1) : '0;
        end
      end
      if (cmd.touch) begin
        slot_ref[cur_slot] <= 1'b1;
      end
      if (cmd.create) begin
        created  <= 1'b1;
        cur_slot <= free_slot[SW-1:0];
        slot_valid[free_slot[SW-1:0]]   <= 1'b1;
        slot_process[free_slot[SW-1:0]] <= r.process_id;
        slot_number[free_slot[SW-1:0]]  <= next_number;
        slot_ref[free_slot[SW-1:0]]     <= 1'b0;
        slot_mod[free_slot[SW-1:0]]     <= 1'b0;
        slot_mask[free_slot[SW-1:0]]    <= '0;
        age_order[order_len[SW-1:0]]    <= free_slot[SW-1:0];
        order_len   <= order_len + LW'(1);
        num_hold    <= next_number;
        next_number <= next_number + 16'd1;
      end
      if (cmd.page_step) begin
        if (!page_used[page_idx]) begin
          page_used[page_idx]           <= 1'b1;
          slot_mask[cur_slot][page_idx] <= 1'b1;
          free_cnt <= free_cnt - CW'(1);
          taken    <= taken + CW'(1);
        end
        page <= page + (PW+1)'(1);
      end
      if (cmd.rel_step) begin
        if (slot_mask[cur_slot][page[PW-1:0]]) begin
          slot_mask[cur_slot][page[PW-1:0]] <= 1'b0;
          if (page_used[page[PW-1:0]]) begin
            page_used[page[PW-1:0]] <= 1'b0;
            free_cnt <= free_cnt + CW'(1);
          end
          released <= released + CW'(1);
        end
        page <= page + (PW+1)'(1);
        pos  <= found_pos;
      end
      if (cmd.shift_step) begin
        if (!sts.shift_done) begin
          age_order[pos_idx] <= age_order[SW'(pos + LW'(1))];
          pos <= pos + LW'(1);
        end
      end
      if (cmd.finish_rm) begin
        slot_valid[cur_slot] <= 1'b0;
        slot_ref[cur_slot]   <= 1'b0;
        slot_mod[cur_slot]   <= 1'b0;
        order_len <= order_len - LW'(1);
        hand <= (found_pos < order_len - LW'(1)) ? found_pos[SW-1:0] : '0;
      end
    end
  end
endmodule

// ===== hdl/spa_ctrl.sv =====
// Controller state machine sequencing each request through the datapath.
`timescale 1ns / 1ps
module spa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    kind,
  input  spa_pkg::sts_t sts,
  output logic          busy,
  output spa_pkg::cmd_t cmd
);
  import spa_pkg::*;
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_PAGES = 10'b0000001000,
    S_FIND  = 10'b0000010000,
    S_WALK  = 10'b0000100000,
    S_REL   = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;
  state_t state, state_next;
  logic [2:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= KIND_ALLOC;
    end else begin
      state <= state_next;
      if (start && state == S_IDLE) k <= kind;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind)
            KIND_ALLOC: state_next = S_DIV;
            KIND_FREE, KIND_TOUCH, KIND_LOOKUP: state_next = S_FIND;
            KIND_EVICT: state_next = S_WALK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_CHECK;
        else cmd.div_step = 1'b1;
      end
      S_CHECK: begin
        if (sts.no_space || sts.table_full || sts.need_zero) begin
          if (!sts.no_space && !sts.table_full) cmd.create = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.create = 1'b1;
          state_next = S_PAGES;
        end
      end
      S_PAGES: begin
        if (sts.page_done) state_next = S_WAIT;
        else cmd.page_step = 1'b1;
      end
      S_FIND: begin
        if (sts.find_done) begin
          if (sts.found && k == KIND_FREE) state_next = S_REL;
          else begin
            if (sts.found && k == KIND_TOUCH) cmd.touch = 1'b1;
            state_next = S_EMIT;
          end
        end else cmd.find_step = 1'b1;
      end
      S_WALK: begin
        if (sts.empty) state_next = S_EMIT;
        else if (sts.walk_done) state_next = S_REL;
        else cmd.walk_step = 1'b1;
      end
      S_REL: begin
        if (sts.rel_done) state_next = S_SHIFT;
        else cmd.rel_step = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          cmd.finish_rm = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/segment_page_allocator_second_chance.sv =====
// Top level of the segment page allocator with second-chance eviction.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its results appear
// one per cycle-long strobe on valid and cannot be held off, all of them
// before busy falls. Allocate runs the serial page-count division and the
// space check, then scans up to PAGES page frames one a cycle. Free and
// evict scan the age order one entry a cycle, sweep all PAGES frames to
// release pages, then close the age order.
module segment_page_allocator_second_chance #(
  parameter int PAGES    = spa_pkg::PAGES_DEF,
  parameter int SEGMENTS = spa_pkg::SEGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spa_pkg::req_t req,
  output logic          valid,
  output spa_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import spa_pkg::*;
  logic [12:0] psz;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {19'd0, psz} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) psz <= PSZ_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) psz <= pwdata[12:0];
  end

  spa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(req.kind), .sts(sts),
    .busy(busy), .cmd(cmd)
  );

  spa_datapath #(.PAGES(PAGES), .SEGMENTS(SEGMENTS)) u_dp (
    .clk(clk), .rst(rst), .req(req), .psz_reg(psz), .cmd(cmd), .sts(sts),
    .rsp(rsp), .strobe(valid)
  );
endmodule

// ===== tb/segment_page_allocator_second_chance_tb.sv =====
// Self-checking testbench for the segment page allocator with second-chance eviction.
`timescale 1ns / 1ps
module segment_page_allocator_second_chance_tb;
  import spa_pkg::*;

  localparam int NPAGES = 64;
  localparam int NSEGS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    bit          is_cfg;
    logic [12:0] cfg_value;
    req_t        request;
    bit          calm;
  } stim_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        valid;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segment_page_allocator_second_chance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .valid(valid), .rsp(rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  stim_t stim_q[$];
  rsp_t  expected_rsp_q[$];
  int    mismatches = 0;
  int    cycle_count = 0;

  // Mirror of the allocator state.
  bit          frame_used[NPAGES];
  int          frames_free;
  bit          seg_live[NSEGS];
  logic [15:0] seg_pid[NSEGS];
  logic [15:0] seg_num[NSEGS];
  bit [63:0]   seg_frames[NSEGS];
  bit          seg_ref[NSEGS];
  bit          seg_mod[NSEGS];
  int          age_q[NSEGS];
  int          age_len;
  int          hand;
  logic [15:0] number_next;
  logic [12:0] page_size;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rsp_t blank_rsp(logic [2:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int oldest_of(logic [15:0] pid);
    for (int p = 0; p < age_len; p++) begin
      if (seg_live[age_q[p]] && seg_pid[age_q[p]] == pid) return p;
    end
    return -1;
  endfunction

  function automatic int drop_segment(int p);
    int s;
    int released;
    s = age_q[p];
    released = 0;
    for (int i = 0; i < NPAGES; i++) begin
      if (seg_frames[s][i]) begin
        if (frame_used[i]) begin
          frame_used[i] = 1'b0;
          frames_free++;
        end
        released++;
      end
    end
    seg_frames[s] = '0;
    seg_live[s] = 1'b0;
    seg_ref[s] = 1'b0;
    seg_mod[s] = 1'b0;
    for (int i = p; i + 1 < age_len; i++) age_q[i] = age_q[i + 1];
    age_len--;
    hand = (p < age_len) ? p : 0;
    return released;
  endfunction

  // Works out the responses of one accepted request and queues them.
  function automatic void allocator_step(req_t r);
    rsp_t o;
    int   psz;
    int   need;
    int   s;
    int   p;
    int   taken;
    psz = (page_size == 0) ? 1 : int'(page_size);
    case (r.kind)
      KIND_ALLOC: begin
        need = (int'(r.size_units) + psz - 1) / psz;
        if (frames_free == 0 || need > frames_free) begin
          expected_rsp_q.push_back(blank_rsp(ST_NO_SPACE));
          return;
        end
        s = 0;
        while (s < NSEGS && seg_live[s]) s++;
        if (age_len >= NSEGS || s >= NSEGS) begin
          expected_rsp_q.push_back(blank_rsp(ST_FULL));
          return;
        end
        seg_live[s] = 1'b1;
        seg_pid[s] = r.process_id;
        seg_num[s] = number_next;
        seg_ref[s] = 1'b0;
        seg_mod[s] = 1'b0;
        seg_frames[s] = '0;
        number_next = number_next + 16'd1;
        age_q[age_len] = s;
        age_len++;
        o = blank_rsp(ST_OK);
        o.segment_number = seg_num[s];
        if (need == 0) begin
          expected_rsp_q.push_back(o);
          return;
        end
        taken = 0;
        for (int i = 0; i < NPAGES && taken < need; i++) begin
          if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            seg_frames[s][i] = 1'b1;
            frames_free--;
            taken++;
            o.page_index = i[5:0];
            o.page_valid = 1'b1;
            o.page_total = need[6:0];
            o.last = (taken == need);
            expected_rsp_q.push_back(o);
          end
        end
      end
      KIND_FREE: begin
        p = oldest_of(r.process_id);
        if (p < 0) begin
          expected_rsp_q.push_back(blank_rsp(ST_NOT_FND));
          return;
        end
        o = blank_rsp(ST_OK);
        o.segment_number = seg_num[age_q[p]];
        o.page_total = 7'(drop_segment(p));
        expected_rsp_q.push_back(o);
      end
      KIND_EVICT: begin
        if (age_len == 0) begin
          expected_rsp_q.push_back(blank_rsp(ST_EMPTY));
          return;
        end
        p = (hand < age_len) ? hand : 0;
        // Referenced segments get a second chance and are marked dirty.
        while (seg_ref[age_q[p]]) begin
          seg_ref[age_q[p]] = 1'b0;
          seg_mod[age_q[p]] = 1'b1;
          p = (p + 1 < age_len) ? p + 1 : 0;
        end
        s = age_q[p];
        o = blank_rsp(ST_OK);
        o.segment_number = seg_num[s];
        o.victim_process = seg_pid[s];
        o.write_back = seg_mod[s];
        o.page_total = 7'(drop_segment(p));
        expected_rsp_q.push_back(o);
      end
      KIND_TOUCH: begin
        p = oldest_of(r.process_id);
        if (p < 0) begin
          expected_rsp_q.push_back(blank_rsp(ST_NOT_FND));
          return;
        end
        seg_ref[age_q[p]] = 1'b1;
        o = blank_rsp(ST_OK);
        o.segment_number = seg_num[age_q[p]];
        expected_rsp_q.push_back(o);
      end
      KIND_LOOKUP: begin
        p = oldest_of(r.process_id);
        o = blank_rsp(ST_OK);
        if (p >= 0) begin
          o.segment_number = seg_num[age_q[p]];
          o.present = 1'b1;
        end
        expected_rsp_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // Driver: requests and register writes, the latter only while idle.
  int gap = 0;
  int quiet = 0;
  bit cur_calm = 1'b0;
  bit next_start;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      gap = 0;
      quiet = 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        allocator_step(req);
        next_start = 1'b0;
        if (!cur_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
      end
      if (psel && penable) begin
        if (pwrite && pready) page_size = pwdata[12:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
      end else if (psel) begin
        penable <= 1'b1;
      end else if (!next_start) begin
        if (gap > 0) begin
          gap--;
        end else if (stim_q.size() > 0) begin
          if (stim_q[0].is_cfg) begin
            // Unknown kinds give no response, so allow the block to settle.
            if (expected_rsp_q.size() != 0) begin
              quiet = 0;
            end else if (quiet < 150) begin
              quiet++;
            end else begin
              psel <= 1'b1;
              pwrite <= 1'b1;
              paddr <= 1'b0;
              pwdata <= {19'd0, stim_q[0].cfg_value};
              void'(stim_q.pop_front());
              quiet = 0;
            end
          end else begin
            req <= stim_q[0].request;
            cur_calm = stim_q[0].calm;
            void'(stim_q.pop_front());
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed response is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %h", rsp);
      end else begin
        if (rsp !== expected_rsp_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", expected_rsp_q[0], rsp);
        end
        void'(expected_rsp_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void add_request(logic [2:0] kind, logic [15:0] pid,
                                      logic [15:0] size, bit calm);
    stim_t t;
    t.is_cfg = 1'b0;
    t.cfg_value = '0;
    t.request.kind = kind;
    t.request.process_id = pid;
    t.request.size_units = size;
    t.calm = calm;
    stim_q.push_back(t);
  endfunction

  function automatic void add_page_size(logic [12:0] v);
    stim_t t;
    t.is_cfg = 1'b1;
    t.cfg_value = v;
    t.request = '0;
    t.calm = 1'b0;
    stim_q.push_back(t);
  endfunction

  function automatic void add_random_phase(logic [12:0] psz, int count, bit calm_tail);
    int          roll;
    int          unit;
    logic [2:0]  kind;
    logic [15:0] pid;
    logic [15:0] size;
    unit = (psz == 0) ? 1 : int'(psz);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 38) kind = KIND_ALLOC;
      else if (roll < 52) kind = KIND_FREE;
      else if (roll < 66) kind = KIND_EVICT;
      else if (roll < 81) kind = KIND_TOUCH;
      else if (roll < 95) kind = KIND_LOOKUP;
      else kind = 3'($urandom_range(5, 7));
      pid = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      roll = $urandom_range(0, 19);
      if (roll == 0) size = 16'hFFFF;
      else if (roll == 1) size = 16'($urandom);
      else if (roll < 4) size = 16'd0;
      else size = 16'($urandom_range(1, unit * 6 > 65535 ? 65535 : unit * 6));
      add_request(kind, pid, size, calm_tail && (i >= count - 40));
    end
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 1'b0;
    pwdata = '0;
    page_size = PSZ_RESET;
    frames_free = NPAGES;
    age_len = 0;
    hand = 0;
    number_next = '0;
    for (int i = 0; i < NPAGES; i++) frame_used[i] = 1'b0;
    for (int s = 0; s < NSEGS; s++) begin
      seg_live[s] = 1'b0;
      seg_ref[s] = 1'b0;
      seg_mod[s] = 1'b0;
      seg_frames[s] = '0;
      age_q[s] = 0;
    end

    // Directed part at the reset page size of four units.
    add_request(KIND_EVICT, 16'd0, 16'd0, 1'b0);       // table empty
    add_request(KIND_ALLOC, 16'd0, 16'd0, 1'b0);       // segment with no pages
    add_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF, 1'b0); // too large
    add_request(KIND_ALLOC, 16'd1, 16'd9, 1'b0);
    add_request(KIND_ALLOC, 16'd0, 16'd256, 1'b0);     // beyond the free frames
    add_request(KIND_ALLOC, 16'd2, 16'd244, 1'b0);     // takes every frame left
    add_request(KIND_ALLOC, 16'd3, 16'd0, 1'b0);       // no frame free at all
    add_request(KIND_TOUCH, 16'd1, 16'd0, 1'b0);
    add_request(KIND_LOOKUP, 16'd0, 16'd0, 1'b0);
    add_request(KIND_LOOKUP, 16'h1234, 16'd0, 1'b0);
    add_request(KIND_FREE, 16'h1234, 16'd0, 1'b0);
    add_request(KIND_TOUCH, 16'hFFFF, 16'd0, 1'b0);
    add_request(KIND_EVICT, 16'd0, 16'd0, 1'b0);
    add_request(KIND_EVICT, 16'd0, 16'd0, 1'b0);       // second chance on the touched one
    add_request(KIND_EVICT, 16'd0, 16'd0, 1'b0);       // dirty victim
    add_request(3'd5, 16'd0, 16'd0, 1'b0);
    add_request(3'd6, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(3'd7, 16'd1, 16'd1, 1'b0);
    add_request(KIND_ALLOC, 16'd5, 16'd1, 1'b0);
    add_request(KIND_ALLOC, 16'd5, 16'd5, 1'b0);       // duplicate process
    add_request(KIND_FREE, 16'd5, 16'd0, 1'b0);

    add_page_size(13'd0);
    add_random_phase(13'd0, 50, 1'b0);
    add_page_size(13'd8191);
    add_random_phase(13'd8191, 40, 1'b0);
    add_page_size(13'd1);
    add_random_phase(13'd1, 60, 1'b0);
    add_page_size(13'd4096);
    add_random_phase(13'd4096, 40, 1'b0);
    add_page_size(13'd2);
    add_random_phase(13'd2, 60, 1'b0);
    add_page_size(13'h0AAA);
    add_random_phase(13'h0AAA, 30, 1'b0);
    add_page_size(13'd4);
    add_random_phase(13'd4, 70, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || start || psel || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
